>>> sv/ehtlp_pkg.sv
// shared types, constants and helper functions for the suffix-tree edge hash table
// no dependencies; imported by ehtlp_ram users and edge_hash_table_linear_probe

package ehtlp_pkg;

    localparam int TABLE_AW    = 12;
    localparam int NODE_W      = 13;
    localparam int CHAR_W      = 8;
    localparam int TIDX_W      = 12;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    typedef logic [TABLE_AW-1:0] t_slot;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] parent_node;
        logic [CHAR_W-1:0] first_char;
        logic [TIDX_W-1:0] first_index;
        logic [TIDX_W-1:0] last_index;
        logic [NODE_W-1:0] child_node;
    } t_entry;

    typedef struct packed {
        logic [NODE_W-1:0] found_child_node;
        logic [TIDX_W-1:0] found_last_index;
        logic [TIDX_W-1:0] found_first_index;
        logic              hit;
        t_status           status;
    } t_result;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_EV,
        S_SH_CLR,
        S_SH_RD,
        S_SH_EV,
        S_OUT
    } t_state;

    // ((node << 8) + char) mod table size
    function automatic t_slot home_slot(input logic [NODE_W-1:0] node,
                                        input logic [CHAR_W-1:0] ch);
        return t_slot'({node, ch});
    endfunction

    // home r lies cyclically in (gap, pos]
    function automatic logic stays_put(input t_slot gap, input t_slot pos, input t_slot r);
        return ((pos >= r) && (r > gap)) || ((r > gap) && (gap > pos)) ||
               ((gap > pos) && (pos >= r));
    endfunction

endpackage

>>> sv/ehtlp_ram.sv
// simple dual-port synchronous ram, one write and one registered read per cycle
// generic; no package dependency

module ehtlp_ram #(
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [1 << AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

>>> sv/edge_hash_table_linear_probe.sv
// linear-probing hash table of suffix-tree edges with backward-shift removal
// depends on ehtlp_pkg and ehtlp_ram
// each probed slot takes a ram read state, then an evaluate state on the single read port;
// m_axis_tvalid is registered out of S_OUT, which waits while the previous result is still held;
// remove adds a clear state, then a read and an evaluate state per slot scanned in the shift
// and a clear per moved entry; only S_IDLE takes commands; an unused cmd goes straight to S_OUT
// reset: sync active low, then a clearing sweep of all 4096 slots with s_axis_tready low

module edge_hash_table_linear_probe
    import ehtlp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cmd, parent_node, first_char, first_index, last_index, child_node, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status, hit, found_first_index, found_last_index, found_child_node
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_state  r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    t_entry  r_key, n_key;
    t_slot   r_idx, n_idx;
    t_slot   r_gap, n_gap;
    t_slot   r_cnt, n_cnt;
    t_result r_res, n_res;
    logic    r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data, n_m_data;

    logic   w_we, w_re;
    t_slot  w_waddr;
    t_entry w_wdata;
    logic [$bits(t_entry)-1:0] w_rdata;
    t_entry w_rd;
    logic   w_accept, w_out_free, w_last, w_find_match, w_rem_match, w_stay;

    ehtlp_ram #(
        .WIDTH ($bits(t_entry)),
        .AW    (TABLE_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd         = t_entry'(w_rdata);
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_out_free   = !r_m_valid || m_axis_tready;
    assign w_last       = &r_cnt;
    assign w_find_match = w_rd.parent_node == r_key.parent_node &&
                          w_rd.first_char == r_key.first_char;
    assign w_rem_match  = w_rd.parent_node == r_key.parent_node &&
                          w_rd.first_index == r_key.first_index;
    assign w_stay       = stays_put(r_gap, r_idx, home_slot(w_rd.parent_node, w_rd.first_char));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (&r_idx) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tdata[1:0])
                        CMD_INSERT, CMD_FIND, CMD_REMOVE: n_state = S_RD;
                        default:                          n_state = S_OUT;
                    endcase
                end
            end
            S_RD: n_state = S_EV;
            S_EV: begin
                unique case (r_cmd)
                    CMD_INSERT: begin
                        n_state = (!w_rd.valid || w_last) ? S_OUT : S_RD;
                    end
                    CMD_FIND: begin
                        n_state = (!w_rd.valid || w_find_match || w_last) ? S_OUT : S_RD;
                    end
                    CMD_REMOVE: begin
                        priority if (!w_rd.valid) n_state = S_OUT;
                        else if (w_rem_match)     n_state = S_SH_CLR;
                        else if (w_last)          n_state = S_OUT;
                        else                      n_state = S_RD;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_SH_CLR: n_state = S_SH_RD;
            S_SH_RD:  n_state = S_SH_EV;
            S_SH_EV: begin
                priority if (!w_rd.valid) n_state = S_OUT;
                else if (w_stay)          n_state = S_SH_RD;
                else                      n_state = S_SH_CLR;
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: handshake and ram port
    always_comb begin
        s_axis_tready = 1'b0;
        w_re          = 1'b0;
        w_we          = 1'b0;
        w_waddr       = r_idx;
        w_wdata       = '0;
        unique case (r_state)
            S_INIT: begin
                w_we = 1'b1;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_RD, S_SH_RD: begin
                w_re = 1'b1;
            end
            S_EV: begin
                if (r_cmd == CMD_INSERT && !w_rd.valid) begin
                    w_we    = 1'b1;
                    w_wdata = r_key;
                end
            end
            S_SH_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_gap;
            end
            S_SH_EV: begin
                if (w_rd.valid && !w_stay) begin
                    w_we    = 1'b1;
                    w_waddr = r_gap;
                    w_wdata = w_rd;
                end
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_idx     = r_idx;
        n_gap     = r_gap;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        unique case (r_state)
            S_INIT: begin
                n_idx = r_idx + 1'b1;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd             = t_cmd'(s_axis_tdata[1:0]);
                    n_key.valid       = 1'b1;
                    n_key.parent_node = s_axis_tdata[14:2];
                    n_key.first_char  = s_axis_tdata[22:15];
                    n_key.first_index = s_axis_tdata[34:23];
                    n_key.last_index  = s_axis_tdata[46:35];
                    n_key.child_node  = s_axis_tdata[59:47];
                    n_idx             = home_slot(s_axis_tdata[14:2], s_axis_tdata[22:15]);
                    n_cnt             = '0;
                    n_res             = '0;
                end
            end
            S_EV: begin
                n_idx = r_idx + 1'b1;
                n_cnt = r_cnt + 1'b1;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        if (w_rd.valid && w_last) n_res.status = ST_FULL;
                    end
                    CMD_FIND: begin
                        priority if (!w_rd.valid) begin
                            n_res.status = ST_NOT_FOUND;
                        end else if (w_find_match) begin
                            n_res.hit               = 1'b1;
                            n_res.found_first_index = w_rd.first_index;
                            n_res.found_last_index  = w_rd.last_index;
                            n_res.found_child_node  = w_rd.child_node;
                        end else if (w_last) begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    end
                    CMD_REMOVE: begin
                        priority if (!w_rd.valid) begin
                            n_res.status = ST_NOT_FOUND;
                        end else if (w_rem_match) begin
                            n_gap = r_idx;
                        end else if (w_last) begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SH_CLR: begin
                n_idx = r_gap + 1'b1;
            end
            S_SH_EV: begin
                if (w_rd.valid) begin
                    if (w_stay) n_idx = r_idx + 1'b1;
                    else        n_gap = r_idx;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {r_res.found_child_node, r_res.found_last_index,
                                 r_res.found_first_index, r_res.hit, r_res.status};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_gap    <= n_gap;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re && w_waddr == r_idx))
        else $error("ram read and write hit the same slot in one cycle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted transaction left no work");

    a_gap_reads_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_EV && r_gap == r_idx) |-> !w_rd.valid)
        else $error("shift scan found the gap slot occupied");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_data[1:0] == ST_OK || r_m_data[1:0] == ST_NOT_FOUND ||
                       r_m_data[1:0] == ST_FULL))
        else $error("illegal status code on output");

    a_hit_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[2]) |-> (r_m_data[1:0] == ST_OK))
        else $error("hit reported with error status");

endmodule
